FILE: src/dors_pkg.sv
// shared types and codes for the date ordered record stack
`default_nettype none

package dors_pkg;

   localparam int KEY_W    = 32;
   localparam int TAG_W    = 16;
   localparam int ACT_W    = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // action codes
   localparam logic [ACT_W-1:0] ACT_SORTED = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // record traveling down the chain
   typedef struct packed {
      logic             tok;    // a record is in flight
      logic             shift;  // placing mode: drop into the next cell unconditionally
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } token_type;

   // broadcast control to every cell
   typedef struct packed {
      logic pop;
      logic clear;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: src/dors_cell.sv
// one list slot: holds a record, compares against a passing record and shifts
`default_nettype none

module dors_cell #(
   parameter bit FRONT = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dors_pkg::cell_ctl_type      ctl,
   input  wire dors_pkg::token_type         tok_in,
   input  wire logic [dors_pkg::KEY_W-1:0]  nxt_key,
   input  wire logic [dors_pkg::TAG_W-1:0]  nxt_tag,
   input  wire logic                        nxt_valid,
   output dors_pkg::token_type              tok_out,
   output logic [dors_pkg::KEY_W-1:0]       key,
   output logic [dors_pkg::TAG_W-1:0]       tag,
   output logic                             valid
);

   logic [dors_pkg::KEY_W-1:0] key_ff, key_in;
   logic [dors_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                       valid_ff, valid_in;
   dors_pkg::token_type        tok_ff, tok_in_nxt;
   logic                       place;

   // front slot takes a strictly larger key, later slots stop at the first key not larger
   always_comb begin
      if (FRONT) begin
         place = tok_in.shift || !valid_ff || (tok_in.key > key_ff);
      end else begin
         place = tok_in.shift || !valid_ff || !(key_ff > tok_in.key);
      end
   end

   always_comb begin
      key_in     = key_ff;
      tag_in     = tag_ff;
      valid_in   = valid_ff;
      tok_in_nxt = '0;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         key_in   = nxt_key;
         tag_in   = nxt_tag;
         valid_in = nxt_valid;
      end else if (tok_in.tok) begin
         if (place) begin
            key_in           = tok_in.key;
            tag_in           = tok_in.tag;
            valid_in         = 1'b1;
            // displaced record keeps moving back
            tok_in_nxt.tok   = valid_ff;
            tok_in_nxt.shift = 1'b1;
            tok_in_nxt.key   = key_ff;
            tok_in_nxt.tag   = tag_ff;
         end else begin
            tok_in_nxt = tok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;
   assign key     = key_ff;
   assign tag     = tag_ff;
   assign valid   = valid_ff;

endmodule

`default_nettype wire

FILE: src/date_ordered_record_stack.sv
// top level of the date ordered record stack: control, chain of slots and result register
`default_nettype none

// A bounded list of up to DEPTH records (32-bit key, 16-bit tag) kept front to
// back in a row of slot cells. Each item on req_ carries an action: sorted push,
// push to front, pop front or clear. Every item gives one result on rsp_ with a
// status (done, rejected because full, pop on empty), the front record after the
// action (zero when empty) and the fill level. Items are taken one at a time.
// A pop, a clear, a rejected push and a push into an empty list pass from
// acceptance through S_EXEC and S_WAIT to the result register. Any other push
// stays in S_WAIT while the new record enters the front slot and walks down the
// chain one slot per cycle, comparing keys, and once placed the displaced
// records ripple back one slot per cycle until an empty slot is reached. The
// result register is separate from the list, so a result may wait on rsp_tready
// while the next item is taken and processed.
module date_ordered_record_stack #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // sort_key [31:0], record_tag [47:32]
   input  wire logic [1:0]  req_tuser,   // action [1:0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // front_key [31:0], front_tag [47:32],
                                         // fill_level [52:48], zero [55:53]
   output logic [1:0]       rsp_tuser    // status [1:0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   // control states
   localparam logic [1:0] S_IDLE = 2'd0;   // waiting for an item
   localparam logic [1:0] S_EXEC = 2'd1;   // chain applies the action
   localparam logic [1:0] S_WAIT = 2'd2;   // records still moving, or result slot busy

   logic [1:0]                    state_ff, state_in;
   logic [dors_pkg::ACT_W-1:0]    act_ff, act_in;
   logic [dors_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [dors_pkg::TAG_W-1:0]    tag_ff, tag_in;
   logic [dors_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [55:0]                   rsp_data_ff, rsp_data_in;
   logic [1:0]                    rsp_user_ff, rsp_user_in;

   logic                          accept;
   logic                          is_push;
   logic                          full;
   logic                          any_tok;
   logic                          finish;
   logic [CNT_W+4:0]              cnt_ext;
   logic [dors_pkg::KEY_W-1:0]    front_key;
   logic [dors_pkg::TAG_W-1:0]    front_tag;

   dors_pkg::cell_ctl_type        ctl;
   dors_pkg::token_type           link [DEPTH+1];
   logic [dors_pkg::KEY_W-1:0]    cell_key [DEPTH];
   logic [dors_pkg::TAG_W-1:0]    cell_tag [DEPTH];
   logic [DEPTH-1:0]              cell_valid;
   logic [DEPTH-1:0]              tok_vec;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_push    = (req_tuser == dors_pkg::ACT_SORTED) || (req_tuser == dors_pkg::ACT_FRONT);
   assign full       = (cnt_ff == CNT_W'(DEPTH));

   // broadcast control and new record injected at the front slot
   always_comb begin
      ctl.pop       = (state_ff == S_EXEC) && (act_ff == dors_pkg::ACT_POP)
                      && (status_ff == dors_pkg::ST_DONE);
      ctl.clear     = (state_ff == S_EXEC) && (act_ff == dors_pkg::ACT_CLEAR);
      link[0].tok   = (state_ff == S_EXEC) && (status_ff == dors_pkg::ST_DONE)
                      && ((act_ff == dors_pkg::ACT_SORTED) || (act_ff == dors_pkg::ACT_FRONT));
      link[0].shift = (act_ff == dors_pkg::ACT_FRONT);
      link[0].key   = key_ff;
      link[0].tag   = tag_ff;
   end

   // the chain of slots
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [dors_pkg::KEY_W-1:0] nk;
      logic [dors_pkg::TAG_W-1:0] nt;
      logic                       nv;

      if (i == DEPTH - 1) begin : g_last
         assign nk = '0;
         assign nt = '0;
         assign nv = 1'b0;
      end else begin : g_mid
         assign nk = cell_key[i+1];
         assign nt = cell_tag[i+1];
         assign nv = cell_valid[i+1];
      end

      dors_cell #(
         .FRONT (i == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .tok_in    (link[i]),
         .nxt_key   (nk),
         .nxt_tag   (nt),
         .nxt_valid (nv),
         .tok_out   (link[i+1]),
         .key       (cell_key[i]),
         .tag       (cell_tag[i]),
         .valid     (cell_valid[i])
      );

      assign tok_vec[i] = link[i+1].tok;
   end

   assign any_tok = |tok_vec;
   assign finish  = (state_ff == S_WAIT) && !any_tok && (!rsp_valid_ff || rsp_tready);

   // front record reads as zero on an empty list
   assign front_key = (cnt_ff != '0) ? cell_key[0] : '0;
   assign front_tag = (cnt_ff != '0) ? cell_tag[0] : '0;
   assign cnt_ext   = {5'd0, cnt_ff};

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      key_in    = key_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in    = req_tuser;
               key_in    = req_tdata[31:0];
               tag_in    = req_tdata[47:32];
               state_in  = S_EXEC;
               status_in = dors_pkg::ST_DONE;
               if (is_push) begin
                  if (full) begin
                     status_in = dors_pkg::ST_FULL;
                  end else begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else if (req_tuser == dors_pkg::ACT_POP) begin
                  if (cnt_ff == '0) begin
                     status_in = dors_pkg::ST_EMPTY;
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end else begin
                  cnt_in = '0;
               end
            end
         end
         S_EXEC: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'd0, cnt_ext[4:0], front_tag, front_key};
         rsp_user_in  = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      tag_ff      <= tag_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // fill count stays within the chain
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   // occupied slots agree with the fill count once the chain has settled
   a_cnt_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(cell_valid) == int'(cnt_ff)))
      else $error("slot valid bits disagree with fill count");

   // at most one record in flight along the chain
   a_one_tok: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one record in flight");

   // an accepted item is applied to the chain in the next cycle
   a_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted item not applied");

   // no record is in flight while waiting for an item
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !any_tok)
      else $error("record moving while idle");

endmodule

`default_nettype wire

FILE: tb/record_order_checker.sv
// checker for the date ordered record stack: watches both channels, predicts and compares results
module record_order_checker
   import dors_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,   // sort_key [31:0], record_tag [47:32]
   input  wire logic [1:0]  req_tuser,   // action [1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,   // front_key [31:0], front_tag [47:32], fill_level [52:48]
   input  wire logic [1:0]  rsp_tuser,   // status [1:0]
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KEY_W-1:0]    key;
      logic [TAG_W-1:0]    tag;
      logic [FILL_W-1:0]   fill;
   } front_view_type;

   front_view_type   expected_fronts[$];
   logic [KEY_W-1:0] list_keys [DEPTH];
   logic [TAG_W-1:0] list_tags [DEPTH];
   int               held;
   int               err_count;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // apply one action to the shadow list and return the front view after it
   function automatic front_view_type apply_list_action(input logic [ACT_W-1:0] act,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [TAG_W-1:0] tag);
      front_view_type view;
      int             slot;
      view.status = ST_DONE;
      case (act)
         ACT_SORTED, ACT_FRONT: begin
            if (held >= DEPTH) begin
               view.status = ST_FULL;
            end else begin
               slot = 0;
               // not above the front: goes behind the front and every strictly greater key
               if (act == ACT_SORTED && held != 0 && !(key > list_keys[0])) begin
                  slot = 1;
                  while (slot < held && list_keys[slot] > key) slot++;
               end
               for (int i = held; i > slot; i--) begin
                  list_keys[i] = list_keys[i-1];
                  list_tags[i] = list_tags[i-1];
               end
               list_keys[slot] = key;
               list_tags[slot] = tag;
               held++;
            end
         end
         ACT_POP: begin
            if (held == 0) begin
               view.status = ST_EMPTY;
            end else begin
               for (int i = 1; i < held; i++) begin
                  list_keys[i-1] = list_keys[i];
                  list_tags[i-1] = list_tags[i];
               end
               held--;
            end
         end
         ACT_CLEAR: begin
            held = 0;
         end
         default: ;
      endcase
      view.key  = (held != 0) ? list_keys[0] : '0;
      view.tag  = (held != 0) ? list_tags[0] : '0;
      view.fill = FILL_W'(held);
      return view;
   endfunction

   always @(posedge clock) begin
      front_view_type got;
      front_view_type want;
      if (reset) begin
         held = 0;
         expected_fronts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[52:48]};
            if (expected_fronts.size() == 0) begin
               report_mismatch("unexpected result", got.key, '0);
            end else begin
               want = expected_fronts.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.key !== want.key)
                  report_mismatch("front_key", got.key, want.key);
               if (got.tag !== want.tag)
                  report_mismatch("front_tag", got.tag, want.tag);
               if (got.fill !== want.fill)
                  report_mismatch("fill_level", got.fill, want.fill);
            end
         end
         if (req_tvalid && req_tready)
            expected_fronts.push_back(apply_list_action(req_tuser, req_tdata[31:0],
                                                        req_tdata[47:32]));
      end
      pending_count <= expected_fronts.size();
      fail_count    <= err_count;
   end

endmodule

FILE: tb/tb_date_ordered_record_stack.sv
// testbench top for the date ordered record stack: clock, reset, stimulus, watchdog and verdict
module tb_date_ordered_record_stack;
   import dors_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16;
   localparam int RAND_PER_PHASE = 270;   // four phases, about 1100 items in all
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES  = 25;    // longest push, into a list of DEPTH - 1 records, walks the whole chain

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;         // sort_key [31:0], record_tag [47:32]
   logic [1:0]  req_tuser  = ACT_SORTED; // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;               // front_key [31:0], front_tag [47:32], fill_level [52:48]
   logic [1:0]  rsp_tuser;               // status [1:0]

   int fail_count;
   int pending_count;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;

   // idle plan per random phase: none, sender only, receiver only, both lightly
   int idle_plan [4] = '{0, 68, 0, 8};
   int stall_plan[4] = '{0, 0, 68, 8};

   date_ordered_record_stack #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   record_order_checker #(
      .DEPTH(DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure, one fresh draw per cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   // count cycles where neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // half full-range keys, the rest extremes and a narrow band so equal keys show up
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(9);
      case (r)
         0:       return '0;
         1:       return '1;
         2, 3, 4: return KEY_W'($urandom_range(7));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // present one item, with an optional random gap first, and hold it until taken
   task automatic push_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {tag, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender holds off until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      logic [ACT_W-1:0] act;
      int               r;
      int               run_left;
      bit               growing;
      run_left = 0;
      growing  = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list corner cases first
      push_item(ACT_POP,    '1, '1);    // pop on empty
      push_item(ACT_CLEAR,  '1, '1);    // clear on empty still done
      push_item(ACT_SORTED, '0, '0);    // sorted push into empty list
      push_item(ACT_SORTED, '1, '1);    // larger key takes the front
      push_item(ACT_SORTED, '1, 16'h1234); // equal key goes behind the front
      push_item(ACT_SORTED, 32'h8000_0000, 16'h8000);
      push_item(ACT_FRONT,  32'd5, 16'h00ff); // plain push ignores order
      push_item(ACT_POP,    '0, '0);
      // fill up to the top with a narrow key band
      for (int i = 0; i < 12; i++)
         push_item(ACT_SORTED, KEY_W'($urandom_range(3)), TAG_W'($urandom));
      push_item(ACT_SORTED, 32'h4000_0000, 16'h5555); // full, rejected
      push_item(ACT_FRONT,  32'h7fff_ffff, 16'haaaa); // full, rejected
      push_item(ACT_POP,    '0, '0);
      push_item(ACT_FRONT,  32'h0000_0001, 16'h0001); // back to full
      push_item(ACT_CLEAR,  '0, '0);    // clear a full list
      wait_drained();

      // random: alternating fill and drain runs so the list swings between empty and full
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_plan[phase];
         rcv_stall_pct = stall_plan[phase];
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            if (run_left == 0) begin
               growing  = !growing;
               run_left = $urandom_range(10, 50);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 3)
               act = ACT_CLEAR;
            else if (growing)
               act = (r < 58) ? ACT_SORTED : (r < 78) ? ACT_FRONT : ACT_POP;
            else
               act = (r < 23) ? ACT_SORTED : (r < 33) ? ACT_FRONT : ACT_POP;
            push_item(act, pick_key(), TAG_W'($urandom));
         end
         wait_drained();
      end

      // let any stray result surface before the verdict
      rcv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
src/dors_pkg.sv
src/dors_cell.sv
src/date_ordered_record_stack.sv
tb/record_order_checker.sv
tb/tb_date_ordered_record_stack.sv
